// ===== sv/prpm_pkg.sv =====
// Shared types, register codes and saturation helpers for the pulse rate power meter.
package prpm_pkg;

  localparam int SCALE_W     = 20;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int READ_W      = 36;
  localparam int ENERGY_W    = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_POWER_SCALE   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_SCALE  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_SCALE = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_SCALE = CFG_INDEX_W'(3);

  // Q16 defaults: 1.30, 1.36, 0.125, 0.01
  localparam logic [SCALE_W-1:0] POWER_SCALE_RST   = SCALE_W'(85197);
  localparam logic [SCALE_W-1:0] ENERGY_SCALE_RST  = SCALE_W'(89129);
  localparam logic [SCALE_W-1:0] VOLTAGE_SCALE_RST = SCALE_W'(8192);
  localparam logic [SCALE_W-1:0] CURRENT_SCALE_RST = SCALE_W'(655);

  localparam logic [63:0] READ_MAX   = (64'd1 << READ_W) - 64'd1;
  localparam logic [63:0] ENERGY_MAX = (64'd1 << ENERGY_W) - 64'd1;

  typedef struct packed {
    logic window_end;
    logic level_edge;
    logic power_edge;
  } sample_t;

  typedef struct packed {
    logic count_saturated;
    logic select_level;
    logic reading_kind;
  } flags_t;

  typedef struct packed {
    logic [SCALE_W-1:0] power;
    logic [SCALE_W-1:0] energy;
    logic [SCALE_W-1:0] voltage;
    logic [SCALE_W-1:0] current;
  } scales_t;

  function automatic logic [READ_W-1:0] cap_read(input logic [63:0] v);
    return (v > READ_MAX) ? READ_MAX[READ_W-1:0] : v[READ_W-1:0];
  endfunction

  function automatic logic [ENERGY_W-1:0] cap_energy(input logic [63:0] v);
    return (v > ENERGY_MAX) ? ENERGY_MAX[ENERGY_W-1:0] : v[ENERGY_W-1:0];
  endfunction

endpackage

// ===== sv/prpm_counter.sv =====
// Input register, saturating pulse counters and the closed-window register.
module prpm_counter
  import prpm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sample_t               in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_BITS-1:0] out_power_cnt,
  output logic [COUNT_BITS-1:0] out_level_cnt,
  output flags_t                out_flags
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic                  r_valid;
  sample_t               r_sample;
  logic [COUNT_BITS-1:0] power_pulses;
  logic [COUNT_BITS-1:0] level_pulses;
  logic                  saturated;
  logic                  select_mode;

  logic                  win_valid;
  logic [COUNT_BITS-1:0] win_power;
  logic [COUNT_BITS-1:0] win_level;
  flags_t                win_flags;

  logic                  win_free;
  logic                  r_take;
  logic                  close_win;
  logic                  p_full;
  logic                  l_full;
  logic [COUNT_BITS-1:0] power_next;
  logic [COUNT_BITS-1:0] level_next;
  logic                  sat_next;

  assign win_free  = !win_valid || out_ready;
  // samples that do not close a window never wait on the downstream side
  assign r_take    = r_valid && (!r_sample.window_end || win_free);
  assign close_win = r_take && r_sample.window_end;
  assign in_ready  = !r_valid || r_take;

  assign p_full     = (power_pulses == CNT_MAX);
  assign l_full     = (level_pulses == CNT_MAX);
  assign power_next = (r_sample.power_edge && !p_full) ? power_pulses + CNT_ONE : power_pulses;
  assign level_next = (r_sample.level_edge && !l_full) ? level_pulses + CNT_ONE : level_pulses;
  assign sat_next   = saturated || (r_sample.power_edge && p_full)
                    || (r_sample.level_edge && l_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_ready) begin
      r_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      r_sample <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_pulses <= '0;
      level_pulses <= '0;
      saturated    <= 1'b0;
      select_mode  <= 1'b0;
    end else if (r_take) begin
      if (r_sample.window_end) begin
        power_pulses <= '0;
        level_pulses <= '0;
        saturated    <= 1'b0;
        select_mode  <= !select_mode;
      end else begin
        power_pulses <= power_next;
        level_pulses <= level_next;
        saturated    <= sat_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (win_free) begin
      win_valid <= close_win;
    end
    if (win_free && close_win) begin
      win_power                 <= power_next;
      win_level                 <= level_next;
      win_flags.reading_kind    <= select_mode;
      win_flags.select_level    <= !select_mode;
      win_flags.count_saturated <= sat_next;
    end
  end

  assign out_valid     = win_valid;
  assign out_power_cnt = win_power;
  assign out_level_cnt = win_level;
  assign out_flags     = win_flags;

endmodule

// ===== sv/prpm_scale.sv =====
// Product stage: pulse counts times the configured Q16 scales.
module prpm_scale
  import prpm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  scales_t                       scales,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COUNT_BITS-1:0]         in_power_cnt,
  input  logic [COUNT_BITS-1:0]         in_level_cnt,
  input  flags_t                        in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COUNT_BITS+SCALE_W-1:0] out_power_prod,
  output logic [COUNT_BITS+SCALE_W-1:0] out_energy_add,
  output logic [COUNT_BITS+SCALE_W-1:0] out_reading_prod,
  output flags_t                        out_flags
);

  localparam int PROD_W = COUNT_BITS + SCALE_W;

  logic               p_valid;
  logic [PROD_W-1:0]  power_prod;
  logic [PROD_W-1:0]  energy_add;
  logic [PROD_W-1:0]  reading_prod;
  flags_t             p_flags;
  logic [SCALE_W-1:0] level_scale;

  assign in_ready    = !p_valid || out_ready;
  assign level_scale = in_flags.reading_kind ? scales.current : scales.voltage;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_ready) begin
      p_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      power_prod   <= PROD_W'(in_power_cnt) * PROD_W'(scales.power);
      energy_add   <= PROD_W'(in_power_cnt) * PROD_W'(scales.energy);
      reading_prod <= PROD_W'(in_level_cnt) * PROD_W'(level_scale);
      p_flags      <= in_flags;
    end
  end

  assign out_valid        = p_valid;
  assign out_power_prod   = power_prod;
  assign out_energy_add   = energy_add;
  assign out_reading_prod = reading_prod;
  assign out_flags        = p_flags;

endmodule

// ===== sv/prpm_energy.sv =====
// Energy accumulator with saturation, output capping and the result register.
module prpm_energy
  import prpm_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int ENERGY_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COUNT_BITS+SCALE_W-1:0] in_power_prod,
  input  logic [COUNT_BITS+SCALE_W-1:0] in_energy_add,
  input  logic [COUNT_BITS+SCALE_W-1:0] in_reading_prod,
  input  flags_t                        in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [READ_W-1:0]             out_power,
  output logic [ENERGY_W-1:0]           out_energy,
  output logic [READ_W-1:0]             out_reading,
  output flags_t                        out_flags
);

  localparam int PROD_W = COUNT_BITS + SCALE_W;
  localparam int SUM_W  = ((ENERGY_BITS > PROD_W) ? ENERGY_BITS : PROD_W) + 1;
  localparam logic [SUM_W-1:0] EN_MAX = SUM_W'({ENERGY_BITS{1'b1}});

  logic                   o_valid;
  logic [READ_W-1:0]      o_power;
  logic [ENERGY_W-1:0]    o_energy;
  logic [READ_W-1:0]      o_reading;
  flags_t                 o_flags;
  logic [ENERGY_BITS-1:0] energy_total;
  logic [ENERGY_BITS-1:0] energy_total_next;
  logic [SUM_W-1:0]       sum;

  assign in_ready = !o_valid || out_ready;

  assign sum               = SUM_W'(energy_total) + SUM_W'(in_energy_add);
  assign energy_total_next = (sum > EN_MAX) ? EN_MAX[ENERGY_BITS-1:0] : sum[ENERGY_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid      <= 1'b0;
      energy_total <= '0;
    end else if (in_ready) begin
      o_valid <= in_valid;
      if (in_valid) begin
        energy_total <= energy_total_next;
      end
    end
    if (in_ready && in_valid) begin
      o_power   <= cap_read(64'(in_power_prod));
      o_energy  <= cap_energy(64'(energy_total_next));
      o_reading <= cap_read(64'(in_reading_prod));
      o_flags   <= in_flags;
    end
  end

  assign out_valid   = o_valid;
  assign out_power   = o_power;
  assign out_energy  = o_energy;
  assign out_reading = o_reading;
  assign out_flags   = o_flags;

endmodule

// ===== sv/pulse_rate_power_meter_core.sv =====
// Top level of the pulse rate power meter: scale registers and the readout pipeline.
//
// One input transfer per clock carries the edge flags of the power pulse line
// (s_tdata[0]) and the voltage/current pulse line (s_tdata[1]); s_tlast marks the
// sample that closes the window. Edges in that sample still count.
// Each closing sample yields one result transfer: power, energy and the voltage or
// current reading in Q16, with kind, new select level and saturation in m_tuser.
// Throughput is one sample per cycle while s_tready is high. A result reaches m_tvalid
// from the closing sample through the input, window, product and output registers.
// When m_tready is low, samples that do not close a window keep flowing; closing
// samples queue in the window, product and output registers, and s_tready drops
// once all three hold results and a further closing sample waits in the input register.
// The scale registers are written through cfg_*; cfg_ready is always high and
// writes to an unknown index are dropped. Scales should only change while idle.
// Reset clears counters, energy total and select mode, and restores default scales.
module pulse_rate_power_meter_core
  import prpm_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int ENERGY_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,    // [0] power_edge, [1] level_edge, rest zero
  input  logic                   s_tlast,    // window_end
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [119:0]           m_tdata,    // [35:0] power_q16, [83:36] energy_q16,
                                             // [119:84] reading_q16
  output logic [2:0]             m_tuser,    // [0] reading_kind, [1] select_level,
                                             // [2] count_saturated
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PROD_W = COUNT_BITS + SCALE_W;

  scales_t               scales;
  sample_t               sample;

  logic                  win_valid;
  logic                  win_ready;
  logic [COUNT_BITS-1:0] win_power_cnt;
  logic [COUNT_BITS-1:0] win_level_cnt;
  flags_t                win_flags;

  logic                  prod_valid;
  logic                  prod_ready;
  logic [PROD_W-1:0]     power_prod;
  logic [PROD_W-1:0]     energy_add;
  logic [PROD_W-1:0]     reading_prod;
  flags_t                prod_flags;

  logic [READ_W-1:0]     power_q16;
  logic [ENERGY_W-1:0]   energy_q16;
  logic [READ_W-1:0]     reading_q16;
  flags_t                res_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scales.power   <= POWER_SCALE_RST;
      scales.energy  <= ENERGY_SCALE_RST;
      scales.voltage <= VOLTAGE_SCALE_RST;
      scales.current <= CURRENT_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POWER_SCALE:   scales.power   <= cfg_data[SCALE_W-1:0];
        REG_ENERGY_SCALE:  scales.energy  <= cfg_data[SCALE_W-1:0];
        REG_VOLTAGE_SCALE: scales.voltage <= cfg_data[SCALE_W-1:0];
        REG_CURRENT_SCALE: scales.current <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign sample.power_edge = s_tdata[0];
  assign sample.level_edge = s_tdata[1];
  assign sample.window_end = s_tlast;

  prpm_counter #(
    .COUNT_BITS(COUNT_BITS)
  ) u_counter (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_sample    (sample),
    .out_valid    (win_valid),
    .out_ready    (win_ready),
    .out_power_cnt(win_power_cnt),
    .out_level_cnt(win_level_cnt),
    .out_flags    (win_flags)
  );

  prpm_scale #(
    .COUNT_BITS(COUNT_BITS)
  ) u_scale (
    .clk             (clk),
    .rst             (rst),
    .scales          (scales),
    .in_valid        (win_valid),
    .in_ready        (win_ready),
    .in_power_cnt    (win_power_cnt),
    .in_level_cnt    (win_level_cnt),
    .in_flags        (win_flags),
    .out_valid       (prod_valid),
    .out_ready       (prod_ready),
    .out_power_prod  (power_prod),
    .out_energy_add  (energy_add),
    .out_reading_prod(reading_prod),
    .out_flags       (prod_flags)
  );

  prpm_energy #(
    .COUNT_BITS (COUNT_BITS),
    .ENERGY_BITS(ENERGY_BITS)
  ) u_energy (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (prod_valid),
    .in_ready       (prod_ready),
    .in_power_prod  (power_prod),
    .in_energy_add  (energy_add),
    .in_reading_prod(reading_prod),
    .in_flags       (prod_flags),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_power      (power_q16),
    .out_energy     (energy_q16),
    .out_reading    (reading_q16),
    .out_flags      (res_flags)
  );

  assign m_tdata = {reading_q16, energy_q16, power_q16};
  assign m_tuser = {res_flags.count_saturated, res_flags.select_level, res_flags.reading_kind};

endmodule
